// ----- rtl/core/vcs_pkg.sv -----
// shared types and constants of the variable coefficient stencil
package vcs_pkg;

  localparam int unsigned CntW   = 10;
  localparam int unsigned DataW  = 32;
  localparam int unsigned ResW   = 64;
  localparam int unsigned AddrW  = 4;

  localparam logic [CntW-1:0]  RowsReset = 10'd40;
  localparam logic [CntW-1:0]  ColsReset = 10'd40;
  localparam logic [DataW-1:0] IxReset   = 32'd2912711;
  localparam logic [DataW-1:0] IyReset   = 32'd6553600;

  typedef enum logic [1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1,
    REG_IX   = 2'd2,
    REG_IY   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CntW-1:0] row;
    logic [CntW-1:0] col;
    logic            last;
  } meta_t;

  // stencil neighborhood of one point, leaving the line stores
  typedef struct packed {
    logic [DataW-1:0] us;
    logic [DataW-1:0] uc;
    logic [DataW-1:0] ue;
    logic [DataW-1:0] uw;
    logic [DataW-1:0] un;
    logic [DataW-1:0] a_s;
    logic [DataW-1:0] a_c;
    logic [DataW-1:0] b_e;
    logic [DataW-1:0] b_c;
  } window_t;

endpackage

// ----- rtl/core/vcs_line_store.sv -----
// line store memories for field and coefficients, with the column window
module vcs_line_store #(
  parameter int unsigned AW = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       acc,
  input  logic                       has_res,
  input  logic                       par,
  input  logic [AW-1:0]              ci,
  input  logic [AW-1:0]              cn,
  input  logic [vcs_pkg::DataW-1:0]  u_in,
  input  logic [vcs_pkg::DataW-1:0]  a_in,
  input  logic [vcs_pkg::DataW-1:0]  b_in,
  input  vcs_pkg::meta_t             meta_in,
  input  logic                       s2_ready,
  output logic                       s1_ready,
  output logic                       s1_valid,
  output vcs_pkg::window_t           s1_win,
  output vcs_pkg::meta_t             s1_meta
);
  import vcs_pkg::*;

  localparam int unsigned Depth = 1 << AW;

  logic [DataW-1:0] field0 [Depth];
  logic [DataW-1:0] field1 [Depth];
  logic [DataW-1:0] xcoef  [Depth];
  logic [DataW-1:0] ycoef  [Depth];

  logic [DataW-1:0] f0_ci_r, f0_cn_r, f1_ci_r, f1_cn_r;
  logic [DataW-1:0] xa_r, yc_r, ye_r, us_r, as_r, uw_r;
  logic             par_r;
  logic             s1_v_r;
  meta_t            meta_r;
  logic [DataW-1:0] uc, ue, un;

  // bank par holds the row two back, the other bank the row just above
  assign uc = par_r ? f0_ci_r : f1_ci_r;
  assign ue = par_r ? f0_cn_r : f1_cn_r;
  assign un = par_r ? f1_ci_r : f0_ci_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      f0_ci_r <= field0[ci];
      f0_cn_r <= field0[cn];
      f1_ci_r <= field1[ci];
      f1_cn_r <= field1[cn];
      xa_r    <= xcoef[ci];
      yc_r    <= ycoef[ci];
      ye_r    <= ycoef[cn];
      if (par) begin
        field1[ci] <= u_in;
      end else begin
        field0[ci] <= u_in;
      end
      xcoef[ci] <= a_in;
      ycoef[ci] <= b_in;
      par_r     <= par;
      us_r      <= u_in;
      as_r      <= a_in;
      // west neighbor is the center of the previous point in the row
      uw_r      <= uc;
      meta_r    <= meta_in;
    end
  end

  assign s1_ready = !s1_v_r || s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= acc && has_res;
    end
  end

  assign s1_valid   = s1_v_r;
  assign s1_meta    = meta_r;
  assign s1_win.us  = us_r;
  assign s1_win.uc  = uc;
  assign s1_win.ue  = ue;
  assign s1_win.uw  = uw_r;
  assign s1_win.un  = un;
  assign s1_win.a_s = as_r;
  assign s1_win.a_c = xa_r;
  assign s1_win.b_e = ye_r;
  assign s1_win.b_c = yc_r;

endmodule

// ----- rtl/core/vcs_datapath.sv -----
// arithmetic pipeline: differences, fluxes, scaling, negation and saturation
module vcs_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       s1_valid,
  input  vcs_pkg::window_t           s1_win,
  input  vcs_pkg::meta_t             s1_meta,
  input  logic [vcs_pkg::DataW-1:0]  ix,
  input  logic [vcs_pkg::DataW-1:0]  iy,
  output logic                       s2_ready,
  output logic                       out_valid,
  input  logic                       out_stall,
  output vcs_pkg::meta_t             out_meta,
  output logic [vcs_pkg::ResW-1:0]   out_value
);
  import vcs_pkg::*;

  localparam int unsigned NSt = 8;

  logic [NSt-1:0] v_r;
  logic [NSt:0]   rdy;
  meta_t          m_r [NSt];

  // stage 2: differences
  logic [32:0] dxs_r, dxn_r, dye_r, dyw_r;
  logic [31:0] cxs_r, cxn_r, cye_r, cyw_r;
  // stage 3: fluxes
  logic [65:0] pxs, pxn, pye, pyw;
  logic [48:0] fxs_r, fxn_r, fye_r, fyw_r;
  // stage 4: flux differences
  logic [49:0] fx_r, fy_r;
  // stage 5: partial products
  logic [56:0] plx_r, ply_r;
  logic [57:0] phx_r, phy_r;
  // stage 6..9
  logic [82:0] wx_r, wy_r;
  logic [83:0] tot_r;
  logic [84:0] neg_r;
  logic [68:0] sh;
  logic [ResW-1:0] res_r;

  assign rdy[NSt] = !out_stall;
  for (genvar k = 0; k < NSt; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end
  assign s2_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= s1_valid;
      end
      for (int k = 1; k < NSt; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      m_r[0] <= s1_meta;
    end
    for (int k = 1; k < NSt; k++) begin
      if (rdy[k]) begin
        m_r[k] <= m_r[k-1];
      end
    end
  end

  assign pxs = $signed(dxs_r) * $signed({1'b0, cxs_r});
  assign pxn = $signed(dxn_r) * $signed({1'b0, cxn_r});
  assign pye = $signed(dye_r) * $signed({1'b0, cye_r});
  assign pyw = $signed(dyw_r) * $signed({1'b0, cyw_r});
  assign sh  = neg_r[84:16];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dxs_r <= {s1_win.us[31], s1_win.us} - {s1_win.uc[31], s1_win.uc};
      dxn_r <= {s1_win.uc[31], s1_win.uc} - {s1_win.un[31], s1_win.un};
      dye_r <= {s1_win.ue[31], s1_win.ue} - {s1_win.uc[31], s1_win.uc};
      dyw_r <= {s1_win.uc[31], s1_win.uc} - {s1_win.uw[31], s1_win.uw};
      cxs_r <= s1_win.a_s;
      cxn_r <= s1_win.a_c;
      cye_r <= s1_win.b_e;
      cyw_r <= s1_win.b_c;
    end
    // floor of product over 2^16
    if (rdy[1]) begin
      fxs_r <= pxs[64:16];
      fxn_r <= pxn[64:16];
      fye_r <= pye[64:16];
      fyw_r <= pyw[64:16];
    end
    if (rdy[2]) begin
      fx_r <= {fxs_r[48], fxs_r} - {fxn_r[48], fxn_r};
      fy_r <= {fye_r[48], fye_r} - {fyw_r[48], fyw_r};
    end
    // split the 50 bit flux into signed high and unsigned low halves
    if (rdy[3]) begin
      plx_r <= fx_r[24:0] * ix;
      ply_r <= fy_r[24:0] * iy;
      phx_r <= 58'($signed(fx_r[49:25]) * $signed({1'b0, ix}));
      phy_r <= 58'($signed(fy_r[49:25]) * $signed({1'b0, iy}));
    end
    if (rdy[4]) begin
      wx_r <= {phx_r, 25'b0} + {26'b0, plx_r};
      wy_r <= {phy_r, 25'b0} + {26'b0, ply_r};
    end
    if (rdy[5]) begin
      tot_r <= {wx_r[82], wx_r} + {wy_r[82], wy_r};
    end
    if (rdy[6]) begin
      neg_r <= 85'd0 - {tot_r[83], tot_r};
    end
    if (rdy[7]) begin
      if ((sh[68:63] == 6'h00) || (sh[68:63] == 6'h3f)) begin
        res_r <= sh[63:0];
      end else if (sh[68]) begin
        res_r <= {1'b1, {(ResW-1){1'b0}}};
      end else begin
        res_r <= {1'b0, {(ResW-1){1'b1}}};
      end
    end
  end

  assign out_valid = v_r[NSt-1];
  assign out_meta  = m_r[NSt-1];
  assign out_value = res_r;

endmodule

// ----- rtl/core/variable_coefficient_stencil.sv -----
// top level of the variable coefficient five point stencil
// Streams a grid in row-major order, one point per transaction, and returns the
// variable-coefficient five-point operator of interior point (i,j) when point
// (i+1,j) arrives. One point is taken every cycle while in_stall is low; each line
// store read is issued at the input transaction and is registered before the
// datapath pipeline. The line stores are not cleared at reset: the first two rows
// of a frame fill them before any result reads them. MAX_ROW_POINTS must be a
// power of two at least N+1.
module variable_coefficient_stencil #(
  parameter int unsigned MAX_ROW_POINTS = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_frame_start,
  input  logic [vcs_pkg::DataW-1:0]    in_u_value,
  input  logic [vcs_pkg::DataW-1:0]    in_a_coeff,
  input  logic [vcs_pkg::DataW-1:0]    in_b_coeff,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [vcs_pkg::CntW-1:0]     out_row,
  output logic [vcs_pkg::CntW-1:0]     out_col,
  output logic [vcs_pkg::ResW-1:0]     out_operator_value,
  output logic                         out_frame_last,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [vcs_pkg::AddrW-1:0]    cfg_paddr,
  input  logic [vcs_pkg::DataW-1:0]    cfg_pwdata,
  output logic [vcs_pkg::DataW-1:0]    cfg_prdata,
  output logic                         cfg_pready
);
  import vcs_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ROW_POINTS);

  logic [CntW-1:0]  rows_r, cols_r, row_r, col_r;
  logic [DataW-1:0] ix_r, iy_r;
  logic [CntW-1:0]  r, c;
  logic             acc, has_res, s1_ready, s2_ready, s1_valid;
  meta_t            meta_in, s1_meta, o_meta;
  window_t          s1_win;
  reg_idx_t         idx;
  logic [AW-1:0]    ci, cn;

  assign cfg_pready = 1'b1;
  assign idx = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= RowsReset;
      cols_r <= ColsReset;
      ix_r   <= IxReset;
      iy_r   <= IyReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (idx)
        REG_ROWS: rows_r <= cfg_pwdata[CntW-1:0];
        REG_COLS: cols_r <= cfg_pwdata[CntW-1:0];
        REG_IX:   ix_r   <= cfg_pwdata;
        REG_IY:   iy_r   <= cfg_pwdata;
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ROWS: cfg_prdata = {{(DataW-CntW){1'b0}}, rows_r};
      REG_COLS: cfg_prdata = {{(DataW-CntW){1'b0}}, cols_r};
      REG_IX:   cfg_prdata = ix_r;
      REG_IY:   cfg_prdata = iy_r;
      default:  cfg_prdata = '0;
    endcase
  end

  assign r   = in_frame_start ? '0 : row_r;
  assign c   = in_frame_start ? '0 : col_r;
  assign acc = in_valid && s1_ready;
  assign in_stall = !s1_ready;
  assign ci  = AW'(c);
  assign cn  = AW'(c) + AW'(1);

  assign has_res = (r >= CntW'(2)) && (r <= rows_r) && (c >= CntW'(1)) && (c < cols_r);
  assign meta_in.row  = r - CntW'(1);
  assign meta_in.col  = c;
  assign meta_in.last = (r - CntW'(1) == rows_r - CntW'(1)) && (c == cols_r - CntW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (acc) begin
      if (c >= cols_r) begin
        col_r <= '0;
        row_r <= (r >= rows_r) ? '0 : r + CntW'(1);
      end else begin
        row_r <= r;
        col_r <= c + CntW'(1);
      end
    end
  end

  vcs_line_store #(.AW(AW)) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .has_res  (has_res),
    .par      (r[0]),
    .ci       (ci),
    .cn       (cn),
    .u_in     (in_u_value),
    .a_in     (in_a_coeff),
    .b_in     (in_b_coeff),
    .meta_in  (meta_in),
    .s2_ready (s2_ready),
    .s1_ready (s1_ready),
    .s1_valid (s1_valid),
    .s1_win   (s1_win),
    .s1_meta  (s1_meta)
  );

  vcs_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_win    (s1_win),
    .s1_meta   (s1_meta),
    .ix        (ix_r),
    .iy        (iy_r),
    .s2_ready  (s2_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_meta  (o_meta),
    .out_value (out_operator_value)
  );

  assign out_row        = o_meta.row;
  assign out_col        = o_meta.col;
  assign out_frame_last = o_meta.last;

endmodule

// ----- tb/stencil_checker.sv -----
// checker for the variable coefficient stencil: predicts operator values and compares results
module stencil_checker
  import vcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_frame_start,
  input  logic [DataW-1:0]   in_u_value,
  input  logic [DataW-1:0]   in_a_coeff,
  input  logic [DataW-1:0]   in_b_coeff,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [CntW-1:0]    out_row,
  input  logic [CntW-1:0]    out_col,
  input  logic [ResW-1:0]    out_operator_value,
  input  logic               out_frame_last,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [AddrW-1:0]   cfg_paddr,
  input  logic [DataW-1:0]   cfg_pwdata,
  input  logic               cfg_pready,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RowPoints = 1024;

  typedef struct {
    logic [CntW-1:0] row;
    logic [CntW-1:0] col;
    logic [ResW-1:0] value;
    logic            last;
  } point_result_t;

  point_result_t   expected_q[$];
  logic [DataW-1:0] u_rows[2][RowPoints];
  logic [DataW-1:0] a_row[RowPoints];
  logic [DataW-1:0] b_row[RowPoints];
  logic [CntW-1:0]  row_cnt, col_cnt;
  logic [CntW-1:0]  grid_m, grid_n;
  logic [DataW-1:0] inv_hx2, inv_hy2;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // floor(coef * diff / 2^16)
  function automatic logic signed [127:0] scaled_flux(input logic [DataW-1:0] coef,
                                                      input logic signed [127:0] diff);
    logic signed [127:0] k;
    k = {96'd0, coef};
    return (k * diff) >>> 16;
  endfunction

  function automatic logic [ResW-1:0] operator_at(
      input logic [DataW-1:0] u_s, u_c, u_e, u_w, u_n,
      input logic [DataW-1:0] a_s, a_c, b_e, b_c,
      input logic [DataW-1:0] ix, iy);
    logic signed [127:0] us, uc, ue, uw, un, fx, fy, ixw, iyw, acc, sh, sat_hi;
    us = $signed(u_s);
    uc = $signed(u_c);
    ue = $signed(u_e);
    uw = $signed(u_w);
    un = $signed(u_n);
    fx = scaled_flux(a_s, us - uc) - scaled_flux(a_c, uc - un);
    fy = scaled_flux(b_e, ue - uc) - scaled_flux(b_c, uc - uw);
    ixw = {96'd0, ix};
    iyw = {96'd0, iy};
    acc = fx * ixw + fy * iyw;
    sh = (-acc) >>> 16;
    sat_hi = {64'd0, 64'h7FFF_FFFF_FFFF_FFFF};
    if (sh > sat_hi) return 64'h7FFF_FFFF_FFFF_FFFF;
    if (sh < -sat_hi - 1) return 64'h8000_0000_0000_0000;
    return sh[63:0];
  endfunction

  task automatic take_point();
    logic [CntW-1:0] r, c, rm1;
    int ci, cn, cw, cur, prv;
    point_result_t e;
    if (in_frame_start) begin
      row_cnt = '0;
      col_cnt = '0;
    end
    r = row_cnt;
    c = col_cnt;
    rm1 = r - 10'd1;
    ci = c;
    cn = (ci + 1) % RowPoints;
    cw = (ci + RowPoints - 1) % RowPoints;
    cur = rm1[0];
    prv = r[0];
    if (r >= 2 && r <= grid_m && c >= 1 && c < grid_n) begin
      e.row = rm1;
      e.col = c;
      e.value = operator_at(in_u_value, u_rows[cur][ci], u_rows[cur][cn], u_rows[cur][cw],
                            u_rows[prv][ci], in_a_coeff, a_row[ci], b_row[cn], b_row[ci],
                            inv_hx2, inv_hy2);
      e.last = (rm1 == grid_m - 10'd1) && (c == grid_n - 10'd1);
      expected_q.push_back(e);
    end
    u_rows[prv][ci] = in_u_value;
    a_row[ci] = in_a_coeff;
    b_row[ci] = in_b_coeff;
    if (c >= grid_n) begin
      col_cnt = '0;
      row_cnt = (r >= grid_m) ? '0 : r + 10'd1;
    end else begin
      col_cnt = c + 10'd1;
    end
  endtask

  task automatic check_result();
    point_result_t e;
    if (expected_q.size() == 0) begin
      $error("unexpected result row %0d col %0d", out_row, out_col);
      fail_count++;
      return;
    end
    e = expected_q.pop_front();
    if (out_row !== e.row) begin
      $error("out_row expected %0d got %0d", e.row, out_row);
      fail_count++;
    end
    if (out_col !== e.col) begin
      $error("out_col expected %0d got %0d", e.col, out_col);
      fail_count++;
    end
    if (out_operator_value !== e.value) begin
      $error("operator_value expected %h got %h", e.value, out_operator_value);
      fail_count++;
    end
    if (out_frame_last !== e.last) begin
      $error("frame_last expected %b got %b", e.last, out_frame_last);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      row_cnt = '0;
      col_cnt = '0;
      grid_m  = RowsReset;
      grid_n  = ColsReset;
      inv_hx2 = IxReset;
      inv_hy2 = IyReset;
      expected_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[3:2]))
          REG_ROWS: grid_m = cfg_pwdata[CntW-1:0];
          REG_COLS: grid_n = cfg_pwdata[CntW-1:0];
          REG_IX:   inv_hx2 = cfg_pwdata;
          REG_IY:   inv_hy2 = cfg_pwdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) take_point();
    end
    pending = expected_q.size();
  end

endmodule

// ----- tb/variable_coefficient_stencil_tb.sv -----
// testbench top: stimulus, flow control and verdict for the variable coefficient stencil
module variable_coefficient_stencil_tb;
  import vcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemTarget = 1750;
  localparam int IdleLimit  = 3000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_frame_start = 1'b0;
  logic [DataW-1:0]   in_u_value = '0;
  logic [DataW-1:0]   in_a_coeff = '0;
  logic [DataW-1:0]   in_b_coeff = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CntW-1:0]    out_row;
  logic [CntW-1:0]    out_col;
  logic [ResW-1:0]    out_operator_value;
  logic               out_frame_last;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [AddrW-1:0]   cfg_paddr = '0;
  logic [DataW-1:0]   cfg_pwdata = '0;
  logic [DataW-1:0]   cfg_prdata;
  logic               cfg_pready;
  int                 fail_count;
  int                 pending;
  int                 points_sent = 0;
  int                 burst_left = 0;
  int                 idle_cycles = 0;

  variable_coefficient_stencil dut (.*);

  stencil_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure, switching between modes
  int stall_mode = 0;
  int stall_left = 0;
  int cyc = 0;
  always @(negedge clk) begin
    cyc <= cyc + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(64, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= (cyc % 4 == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [DataW-1:0] pick_value();
    logic [DataW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 3))
          0: v = 32'h0000_0000;
          1: v = 32'hFFFF_FFFF;
          2: v = 32'h8000_0000;
          default: v = 32'h7FFF_FFFF;
        endcase
      end
      2, 3, 4, 5: begin
        v = $urandom;
        v = {{12{v[31]}}, v[19:0]};
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [DataW-1:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return IxReset;
      3: return $urandom_range(0, 32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  // called and returns at a falling edge
  task automatic send_point(input logic fs, input logic [DataW-1:0] u, a, b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_frame_start = fs;
    in_u_value = u;
    in_a_coeff = a;
    in_b_coeff = b;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    points_sent++;
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [DataW-1:0] val);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  // drain all results plus pipeline latency before touching registers
  task automatic set_grid(input int m, n, input logic [DataW-1:0] ix, iy);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    cfg_write(REG_ROWS, m);
    cfg_write(REG_COLS, n);
    cfg_write(REG_IX, ix);
    cfg_write(REG_IY, iy);
  endtask

  // one frame of random content; with noise it may be cut short or lack its start mark
  task automatic send_frame(input int m, n, input bit noise);
    int total, stop;
    bit mark;
    total = (m + 1) * (n + 1);
    stop = (noise && $urandom_range(0, 9) == 0) ? $urandom_range(1, total) : total;
    mark = !(noise && $urandom_range(0, 9) == 0);
    for (int k = 0; k < stop; k++)
      send_point(mark && k == 0, pick_value(), pick_value(), pick_value());
  endtask

  int m, n;

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // saturating extremes on a grid with four interior points
    set_grid(3, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int k = 0; k < 16; k++)
      send_point(k == 0, (k % 2) ? 32'h7FFF_FFFF : 32'h8000_0000,
                 (k % 3) ? 32'hFFFF_FFFF : 32'h0, (k % 2) ? 32'h0 : 32'hFFFF_FFFF);
    // zero scales: single interior point
    set_grid(2, 2, 32'h0, 32'h0);
    for (int k = 0; k < 9; k++)
      send_point(k == 0, pick_value(), pick_value(), pick_value());

    for (int phase = 0; points_sent < ItemTarget || phase < 8; phase++) begin
      case (phase)
        2: begin m = 1; n = 4; end
        4: begin m = 2; n = 255; end
        6: begin m = 63; n = 2; end
        default: begin m = $urandom_range(2, 7); n = $urandom_range(2, 9); end
      endcase
      set_grid(m, n, pick_scale(), pick_scale());
      send_frame(m, n, 1'b0);
      if (m < 10 && n < 10)
        repeat (3) send_frame(m, n, 1'b1);
    end

    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
